### hdl/fxd_pkg.sv
`default_nettype none
package fxd_pkg;

  localparam int unsigned IBCD_DIGITS = 10;
  localparam int unsigned FBCD_DIGITS = 5;
  localparam int unsigned IBITS_PER_STAGE = 8;
  localparam int unsigned FBITS_PER_STAGE = 4;
  localparam int unsigned BCD_STAGES = 5;

  localparam logic [31:0] POS_INF  = 32'h7f800000;
  localparam logic [31:0] NEG_INF  = 32'hff800000;
  localparam logic [31:0] NEG_ZERO = 32'h80000000;
  localparam logic [31:0] ABS_MASK = 32'h7FFFFFFF;
  localparam logic [30:0] INT_SAT  = 31'h7FFFFFFF;
  localparam logic [7:0]  EXP_BIAS_INT = 8'd150;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_BLANK = 8'h20;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_PLUS  = 8'h2B;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_PINF = 2'd1,
    SP_NINF = 2'd2,
    SP_NAN  = 2'd3
  } special_t;

  typedef enum logic [1:0] {
    REG_INT_DIGITS   = 2'd0,
    REG_FRACT_DIGITS = 2'd1,
    REG_SEPARATOR    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] idig;
    logic [2:0] fdig;
    logic [7:0] sep;
  } cfg_t;

  typedef struct packed {
    special_t    special;
    logic        neg;
    logic [30:0] ipart;
    logic [23:0] fb;
    logic [5:0]  sh;
  } dec_t;

  // integer binary is padded to BCD_STAGES * IBITS_PER_STAGE bits
  typedef struct packed {
    special_t    special;
    logic        neg;
    logic [39:0] ibin;
    logic [19:0] fbin;
    logic [39:0] ibcd;
    logic [19:0] fbcd;
  } bcd_t;

  typedef struct packed {
    logic busy;
    logic idx_ok;
  } ser_stat_t;

  function automatic logic [16:0] pow10(input logic [2:0] f);
    logic [16:0] p;
    unique case (f)
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd100000;
    endcase
    return p;
  endfunction

  function automatic logic [39:0] dd_i(input logic [39:0] b, input logic bin);
    logic [39:0] t;
    t = b;
    for (int d = 0; d < 10; d++) begin
      if (t[d*4 +: 4] >= 4'd5) t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
    end
    return {t[38:0], bin};
  endfunction

  function automatic logic [19:0] dd_f(input logic [19:0] b, input logic bin);
    logic [19:0] t;
    t = b;
    for (int d = 0; d < 5; d++) begin
      if (t[d*4 +: 4] >= 4'd5) t[d*4 +: 4] = t[d*4 +: 4] + 4'd3;
    end
    return {t[18:0], bin};
  endfunction

  function automatic logic [7:0] spec_char(input special_t s, input int k);
    logic [7:0] c;
    c = CH_BLANK;
    unique case (s)
      SP_PINF, SP_NINF: begin
        if (k == 0) c = (s == SP_PINF) ? CH_PLUS : CH_MINUS;
        else if (k == 1) c = 8'h69;
        else if (k == 2) c = 8'h6E;
        else if (k == 3) c = 8'h66;
      end
      SP_NAN: begin
        if (k == 0 || k == 2) c = 8'h6E;
        else if (k == 1) c = 8'h61;
      end
      default: c = CH_BLANK;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/fxd_if.sv
`default_nettype none
interface fxd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_bits;
  modport source (output valid, output float_bits, input ready);
  modport sink (input valid, input float_bits, output ready);
endinterface

interface fxd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

interface fxd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/fxd_decode.sv
`default_nettype none
module fxd_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [31:0]   bits_in,
  input  wire fxd_pkg::cfg_t cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fxd_pkg::bcd_t      out_data
);

  logic          v1_r, v2_r;
  fxd_pkg::dec_t d1_r, d1_nxt;
  fxd_pkg::bcd_t d2_r, d2_nxt;
  logic          rdy2;

  logic [31:0] b;
  logic [7:0]  ex, s8, sh8;
  logic [23:0] mant;
  logic [31:0] v;
  logic [40:0] prod;

  always_comb begin
    b = (bits_in == fxd_pkg::NEG_ZERO) ? 32'd0 : bits_in;
    ex = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    mant = {b[30:23] != 8'd0, b[22:0]};
    s8 = ex - fxd_pkg::EXP_BIAS_INT;
    sh8 = fxd_pkg::EXP_BIAS_INT - ex;
    v = {8'd0, mant} << s8[2:0];
    d1_nxt.neg = b[31];
    d1_nxt.ipart = '0;
    d1_nxt.fb = '0;
    d1_nxt.sh = '0;
    if (b == fxd_pkg::POS_INF) d1_nxt.special = fxd_pkg::SP_PINF;
    else if (b == fxd_pkg::NEG_INF) d1_nxt.special = fxd_pkg::SP_NINF;
    else if ((b & fxd_pkg::ABS_MASK) > fxd_pkg::POS_INF) d1_nxt.special = fxd_pkg::SP_NAN;
    else d1_nxt.special = fxd_pkg::SP_NONE;
    if (ex >= fxd_pkg::EXP_BIAS_INT) begin
      if (s8 >= 8'd8 || v[31]) d1_nxt.ipart = fxd_pkg::INT_SAT;
      else d1_nxt.ipart = v[30:0];
    end else if (sh8 < 8'd48) begin
      d1_nxt.ipart = {7'd0, mant >> sh8[5:0]};
      d1_nxt.fb = mant & ~(24'hFFFFFF << sh8[5:0]);
      d1_nxt.sh = sh8[5:0];
    end
  end

  always_comb begin
    prod = {17'd0, d1_r.fb} * {24'd0, fxd_pkg::pow10(cfg.fdig)};
    d2_nxt.special = d1_r.special;
    d2_nxt.neg = d1_r.neg;
    d2_nxt.ibin = {9'd0, d1_r.ipart};
    d2_nxt.fbin = {3'd0, 17'(prod >> d1_r.sh)};
    d2_nxt.ibcd = '0;
    d2_nxt.fbcd = '0;
  end

  assign rdy2 = !v2_r || out_ready;
  assign in_ready = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
    if (in_ready && in_valid) d1_r <= d1_nxt;
    if (rdy2 && v1_r) d2_r <= d2_nxt;
  end

  assign out_valid = v2_r;
  assign out_data = d2_r;

endmodule
`default_nettype wire

### hdl/fxd_dd.sv
`default_nettype none
module fxd_dd (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fxd_pkg::bcd_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fxd_pkg::bcd_t      out_data
);

  logic          v_r;
  fxd_pkg::bcd_t d_r, d_nxt;

  // shift a slice of both binaries into their BCD accumulators
  always_comb begin
    d_nxt = in_data;
    for (int i = 0; i < fxd_pkg::IBITS_PER_STAGE; i++) begin
      d_nxt.ibcd = fxd_pkg::dd_i(d_nxt.ibcd, d_nxt.ibin[39]);
      d_nxt.ibin = {d_nxt.ibin[38:0], 1'b0};
    end
    for (int i = 0; i < fxd_pkg::FBITS_PER_STAGE; i++) begin
      d_nxt.fbcd = fxd_pkg::dd_f(d_nxt.fbcd, d_nxt.fbin[19]);
      d_nxt.fbin = {d_nxt.fbin[18:0], 1'b0};
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) d_r <= d_nxt;
  end

  assign out_valid = v_r;
  assign out_data = d_r;

endmodule
`default_nettype wire

### hdl/fxd_ser.sv
`default_nettype none
module fxd_ser #(
  parameter int unsigned MAX_INT_DIGITS = 10,
  parameter int unsigned MAX_FRACT_DIGITS = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire fxd_pkg::bcd_t in_data,
  input  wire fxd_pkg::cfg_t cfg,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_char,
  output logic               out_last,
  output fxd_pkg::ser_stat_t stat
);

  localparam int unsigned LEN = MAX_INT_DIGITS + 1 + MAX_FRACT_DIGITS;
  localparam int unsigned BUF = (LEN > 4) ? LEN : 4;
  localparam int unsigned IW = $clog2(BUF);
  localparam int unsigned LW = $clog2(BUF + 1);

  logic [7:0]    buf_r [BUF];
  logic [7:0]    buf_nxt [BUF];
  logic [LW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r;
  logic          busy_r, oval_r;
  logic [7:0]    ochar_r;
  logic          olast_r;

  logic [7:0] ich [fxd_pkg::IBCD_DIGITS];
  logic [7:0] fch [fxd_pkg::FBCD_DIGITS];
  logic       nz [fxd_pkg::IBCD_DIGITS + 1];
  logic       can_emit, emit, last_char, load_ok;

  always_comb begin
    int j;
    int d;
    nz[fxd_pkg::IBCD_DIGITS] = 1'b0;
    for (int q = fxd_pkg::IBCD_DIGITS - 1; q >= 0; q--) begin
      nz[q] = nz[q+1] || (in_data.ibcd[q*4 +: 4] != 4'd0);
    end
    for (int q = 0; q < fxd_pkg::IBCD_DIGITS; q++) begin
      if (nz[q]) ich[q] = fxd_pkg::CH_ZERO + {4'd0, in_data.ibcd[q*4 +: 4]};
      else if (q == 0) ich[q] = fxd_pkg::CH_ZERO;
      else if (in_data.neg && (q == 1 || nz[q-1])) ich[q] = fxd_pkg::CH_MINUS;
      else ich[q] = fxd_pkg::CH_BLANK;
    end
    for (int q = 0; q < fxd_pkg::FBCD_DIGITS; q++) begin
      fch[q] = fxd_pkg::CH_ZERO + {4'd0, in_data.fbcd[q*4 +: 4]};
    end
    for (int k = 0; k < BUF; k++) begin
      j = int'(cfg.idig) - 1 - k;
      d = int'(cfg.fdig) - 1 - (k - int'(cfg.idig) - 1);
      if (in_data.special != fxd_pkg::SP_NONE) buf_nxt[k] = fxd_pkg::spec_char(in_data.special, k);
      else if (k < int'(cfg.idig)) buf_nxt[k] = ich[4'(j)];
      else if (k == int'(cfg.idig)) buf_nxt[k] = cfg.sep;
      else if (d >= 0 && d < fxd_pkg::FBCD_DIGITS) buf_nxt[k] = fch[3'(d)];
      else buf_nxt[k] = fxd_pkg::CH_BLANK;
    end
    unique case (in_data.special)
      fxd_pkg::SP_PINF, fxd_pkg::SP_NINF: len_nxt = LW'(4);
      fxd_pkg::SP_NAN: len_nxt = LW'(3);
      default: len_nxt = LW'(cfg.idig) + LW'(cfg.fdig) + LW'(1);
    endcase
  end

  assign can_emit = !oval_r || out_ready;
  assign emit = busy_r && can_emit;
  assign last_char = (LW'(idx_r) + LW'(1)) == len_r;
  assign load_ok = !busy_r || (emit && last_char);
  assign in_ready = load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      oval_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load_ok) begin
        busy_r <= in_valid;
        idx_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + IW'(1);
      end
      if (can_emit) oval_r <= emit;
    end
    if (load_ok && in_valid) begin
      buf_r <= buf_nxt;
      len_r <= len_nxt;
    end
    if (emit) begin
      ochar_r <= buf_r[idx_r];
      olast_r <= last_char;
    end
  end

  assign out_valid = oval_r;
  assign out_char = ochar_r;
  assign out_last = olast_r;
  assign stat.busy = busy_r;
  assign stat.idx_ok = LW'(idx_r) < len_r;

endmodule
`default_nettype wire

### hdl/float_to_fixed_decimal_ascii.sv
`default_nettype none
// channel | dir | payload                 | handshake
// in_ch   | in  | float_bits[31:0]        | valid/ready
// out_ch  | out | character[7:0], last    | valid/ready
// cfg_ch  | in  | index[1:0], data[7:0]   | valid/ready, ready always high
// A word goes through decode, multiply and five BCD stages, then a formatter loads
// the serializer. Sustained rate is one character per cycle while out_ch is ready,
// set by the one-character output register; a number is idig+1+fdig characters,
// 4 for infinities, 3 for nan.
// Synchronous active-low reset clears valids and restores register defaults.
// Stalls on out_ch back up stage by stage; nothing is dropped or repeated.
module float_to_fixed_decimal_ascii #(
  parameter int unsigned MAX_INT_DIGITS = 10,
  parameter int unsigned MAX_FRACT_DIGITS = 5
) (
  input wire logic   clk,
  input wire logic   rst_n,
  fxd_in_if.sink     in_ch,
  fxd_out_if.source  out_ch,
  fxd_cfg_if.sink    cfg_ch
);

  logic [3:0] idig_r;
  logic [2:0] fdig_r;
  logic [7:0] sep_r;
  fxd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idig_r <= 4'd3;
      fdig_r <= 3'd2;
      sep_r <= 8'd46;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fxd_pkg::REG_INT_DIGITS: idig_r <= cfg_ch.data[3:0];
        fxd_pkg::REG_FRACT_DIGITS: fdig_r <= cfg_ch.data[2:0];
        fxd_pkg::REG_SEPARATOR: sep_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg.idig = (idig_r > 4'(MAX_INT_DIGITS)) ? 4'(MAX_INT_DIGITS) : idig_r;
    if (fdig_r == 3'd0) cfg.fdig = 3'd1;
    else if (fdig_r > 3'(MAX_FRACT_DIGITS)) cfg.fdig = 3'(MAX_FRACT_DIGITS);
    else cfg.fdig = fdig_r;
    cfg.sep = sep_r;
  end

  logic          sv [fxd_pkg::BCD_STAGES + 1];
  logic          sr [fxd_pkg::BCD_STAGES + 1];
  fxd_pkg::bcd_t sd [fxd_pkg::BCD_STAGES + 1];
  fxd_pkg::ser_stat_t stat;

  fxd_decode u_dec (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .bits_in(in_ch.float_bits),
    .cfg,
    .out_valid(sv[0]), .out_ready(sr[0]), .out_data(sd[0])
  );

  for (genvar g = 0; g < fxd_pkg::BCD_STAGES; g++) begin : g_dd
    fxd_dd u_dd (
      .clk, .rst_n,
      .in_valid(sv[g]), .in_ready(sr[g]), .in_data(sd[g]),
      .out_valid(sv[g+1]), .out_ready(sr[g+1]), .out_data(sd[g+1])
    );
  end

  fxd_ser #(
    .MAX_INT_DIGITS(MAX_INT_DIGITS), .MAX_FRACT_DIGITS(MAX_FRACT_DIGITS)
  ) u_ser (
    .clk, .rst_n,
    .in_valid(sv[fxd_pkg::BCD_STAGES]), .in_ready(sr[fxd_pkg::BCD_STAGES]),
    .in_data(sd[fxd_pkg::BCD_STAGES]), .cfg,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_char(out_ch.character), .out_last(out_ch.last), .stat
  );

  a_idx: assert property (@(posedge clk) disable iff (!rst_n) stat.busy |-> stat.idx_ok)
    else $error("serializer index past text length");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> stat.busy || out_ch.valid)
    else $error("pending word lost");

endmodule
`default_nettype wire
